// ----- hw/rtl/cfx_pkg.sv -----
// Shared types and constants of the 3x3 convolution / threshold filter.
// Pixel, window column and result tag types, register indexes and request codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfx_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int PIX_W   = 8;
    localparam int FRAC_W  = 12;
    localparam int KERN_W  = 48;
    localparam int LVL_W   = 24;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // One color channel, one RGB pixel (red in index 0) and one window column
    // (top row in index 0).
    typedef logic [PIX_W-1:0] t_chan;
    typedef t_chan [2:0] t_pix;
    typedef t_pix [2:0] t_col;

    // Position flags that travel with each result through the datapath.
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_tag;

    // Kind of an input transfer.
    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_KERN_TOP     = 3'd2,
        REG_KERN_MID     = 3'd3,
        REG_KERN_BOT     = 3'd4,
        REG_BIN_LEVEL    = 3'd5,
        REG_BIN_ENABLE   = 3'd6
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- hw/rtl/conv3x3_threshold_filter_core.sv -----
// 3x3 convolution / threshold filter over an RGB raster, streaming with back-pressure.
// One input transfer per clock unless the output stalls; a result passes the product,
// sum and output registers after its releasing transfer (one row plus one pixel later).
// Reset (synchronous, active low): registers to defaults, position and window to zero;
// the line memory is not cleared, it is always written before it is read.
// Depends on cfx_pkg, cfx_line_mem, cfx_win_cell and cfx_mac.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_threshold_filter_core
    import cfx_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // Input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [23:0]        s_tdata,   // pix_red, pix_green, pix_blue
    input  wire logic [0:0]         s_tuser,   // req_type
    // Output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,   // out_red, out_green, out_blue
    output logic                    m_tlast,   // row_end
    output logic [0:0]              m_tuser    // frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = (WW > FW_W) ? WW : FW_W;
    localparam int YW = FH_W + 1;

    // Configuration registers.
    logic [FW_W-1:0]         r_frame_width;
    logic [FH_W-1:0]         r_frame_height;
    logic [KERN_W-1:0]       r_kern_top, r_kern_mid, r_kern_bot;
    logic signed [LVL_W-1:0] r_bin_level;
    logic                    r_bin_en;
    logic                    cfg_wr;
    t_reg_idx                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(1024);
            r_frame_height <= FH_W'(768);
            r_kern_top     <= '0;
            r_kern_mid     <= KERN_W'(268435456);
            r_kern_bot     <= '0;
            r_bin_level    <= '0;
            r_bin_en       <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                REG_KERN_TOP:     r_kern_top     <= pwdata[KERN_W-1:0];
                REG_KERN_MID:     r_kern_mid     <= pwdata[KERN_W-1:0];
                REG_KERN_BOT:     r_kern_bot     <= pwdata[KERN_W-1:0];
                REG_BIN_LEVEL:    r_bin_level    <= pwdata[LVL_W-1:0];
                REG_BIN_ENABLE:   r_bin_en       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            REG_KERN_TOP:     prdata = PDATA_W'(r_kern_top);
            REG_KERN_MID:     prdata = PDATA_W'(r_kern_mid);
            REG_KERN_BOT:     prdata = PDATA_W'(r_kern_bot);
            REG_BIN_LEVEL:    prdata = PDATA_W'(unsigned'(r_bin_level));
            REG_BIN_ENABLE:   prdata = PDATA_W'(r_bin_en);
            default:          prdata = '0;
        endcase
    end

    // Effective frame geometry.
    logic [CW-1:0] fw_ext;
    logic [WW-1:0] eff_w;
    logic [FH_W-1:0] eff_h;
    logic [YW-1:0] h_p1;

    assign fw_ext = CW'(r_frame_width);
    always_comb begin
        if (fw_ext == '0) begin
            eff_w = WW'(1);
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_ext);
        end
    end
    assign eff_h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    assign h_p1  = YW'(eff_h) + YW'(1);

    // Slot position and per-transfer decisions.
    logic [XW-1:0] r_x, n_x, x;
    logic [YW-1:0] r_y, n_y, y;
    logic          restart, is_drain, in_frame, take, skip, rdy_out, emit, at_col0;
    logic          accept, mac_ready;

    assign restart  = (WW'(r_x) >= eff_w) || (r_y > h_p1) || ((r_y == h_p1) && (r_x != '0));
    assign x        = restart ? '0 : r_x;
    assign y        = restart ? '0 : r_y;
    assign is_drain = (t_req'(s_tuser[0]) == REQ_DRAIN);
    assign in_frame = (y < YW'(eff_h));
    assign take     = !is_drain && in_frame;
    assign skip     = is_drain && in_frame;
    assign rdy_out  = (y >= YW'(2)) || ((y == YW'(1)) && (x != '0));
    assign emit     = rdy_out && !skip;
    assign at_col0  = (x == '0);
    assign s_tready = mac_ready;
    assign accept   = s_tvalid && mac_ready;

    always_comb begin
        if (skip) begin
            n_x = x;
            n_y = y;
        end else if (y == h_p1) begin
            n_x = '0;
            n_y = '0;
        end else if (WW'(x) + WW'(1) >= eff_w) begin
            n_x = '0;
            n_y = y + YW'(1);
        end else begin
            n_x = XW'(WW'(x) + WW'(1));
            n_y = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // Line memory: older row in the upper half, newer row in the lower half.
    logic [2*$bits(t_pix)-1:0] mem_q;
    t_pix                      pix_in, line_a, line_b;
    logic                      mem_we;

    assign pix_in = t_pix'(s_tdata);
    assign line_a = t_pix'(mem_q[2*$bits(t_pix)-1:$bits(t_pix)]);
    assign line_b = t_pix'(mem_q[$bits(t_pix)-1:0]);
    assign mem_we = accept && take;

    cfx_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW),
        .DW    (2*$bits(t_pix))
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (x),
        .i_wdata ({line_b, pix_in}),
        .i_raddr (accept ? n_x : r_x),
        .o_rdata (mem_q)
    );

    // New window column, replicating the frame edge on the first and last rows.
    t_col new_col;
    always_comb begin
        if (y == '0) begin
            new_col[0] = pix_in;
            new_col[1] = pix_in;
            new_col[2] = pix_in;
        end else begin
            new_col[0] = (y == YW'(1)) ? line_b : line_a;
            new_col[1] = line_b;
            new_col[2] = take ? pix_in : line_b;
        end
    end

    // Window chain: two column cells, older first; the newest column is new_col.
    // The oldest column of the window is never read, so it needs no cell.
    t_col win1, win2;
    logic win_shift;

    assign win_shift = accept && !skip;

    cfx_win_cell u_cell1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (win_shift), .i_col (win2), .o_col (win1)
    );
    cfx_win_cell u_cell2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (win_shift), .i_col (new_col), .o_col (win2)
    );

    // Tap selection. At column zero the last pixel of the previous row is due,
    // taken from the window before the shift; otherwise the pixel one column
    // back, taken from the shifted window. Edges repeat the border column.
    t_col [2:0] taps;
    t_tag       tag;
    always_comb begin
        if (at_col0) begin
            taps[0] = (eff_w > WW'(1)) ? win1 : win2;
            taps[1] = win2;
            taps[2] = win2;
        end else begin
            taps[0] = (x == XW'(1)) ? win2 : win1;
            taps[1] = win2;
            taps[2] = new_col;
        end
        tag.row_end   = at_col0;
        tag.frame_end = at_col0 && (y == h_p1);
    end

    // Arithmetic pipeline and output register.
    t_pix out_pix;
    t_tag out_tag;

    cfx_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && emit),
        .o_ready     (mac_ready),
        .i_taps      (taps),
        .i_tag       (tag),
        .i_kern      ({r_kern_bot, r_kern_mid, r_kern_top}),
        .i_level     (r_bin_level),
        .i_bin_en    (r_bin_en),
        .o_valid     (m_tvalid),
        .i_out_ready (m_tready),
        .o_pix       (out_pix),
        .o_tag       (out_tag)
    );

    assign m_tdata    = out_pix;
    assign m_tlast    = out_tag.row_end;
    assign m_tuser[0] = out_tag.frame_end;

endmodule

`default_nettype wire

// ----- hw/rtl/cfx_line_mem.sv -----
// Line buffer memory holding the two previous rows of pixels, packed per column.
// One write and one registered read per cycle, with write-to-read forwarding.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfx_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_byp_data;
    logic          r_byp;

    // Storage array with registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q        <= r_mem[i_raddr];
        r_byp_data <= i_wdata;
    end

    // A read of the address being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cfx_win_cell.sv -----
// One column cell of the 3x3 window chain; each cell passes its column on.
// Depends on cfx_pkg for the column type.
`timescale 1ns / 1ps
`default_nettype none

module cfx_win_cell
    import cfx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire t_col i_col,
    output t_col      o_col
);

    t_col r_col;

    // Take the neighbor's column whenever the window shifts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ----- hw/rtl/cfx_mac.sv -----
// Arithmetic pipeline: 27 tap products, per-channel sums, then rounding and
// clamping or thresholding into the output register. Depends on cfx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfx_mac
    import cfx_pkg::*;
#(
    parameter int COEF_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    output logic                                o_ready,
    input  wire t_col [2:0]                     i_taps,
    input  wire t_tag                           i_tag,
    input  wire logic [2:0][KERN_W-1:0]         i_kern,
    input  wire logic signed [LVL_W-1:0]        i_level,
    input  wire logic                           i_bin_en,
    output logic                                o_valid,
    input  wire logic                           i_out_ready,
    output t_pix                                o_pix,
    output t_tag                                o_tag
);

    localparam int PW  = COEF_BITS + PIX_W + 1;
    localparam int SW0 = COEF_BITS + PIX_W + 5;
    localparam int SW  = (SW0 > LVL_W + 1) ? SW0 : LVL_W + 1;

    logic signed [PW-1:0] n_prod [3][3][3];
    logic signed [PW-1:0] r_prod [3][3][3];
    logic signed [SW-1:0] n_sum [3];
    logic signed [SW-1:0] r_sum [3];
    logic signed [SW:0]   rnd [3];
    t_pix                 n_pix;
    t_pix                 r_pix;
    t_tag                 r_tag1, r_tag2, r_tag3;
    logic                 r_v1, r_v2, r_v3;
    logic                 free1, free2, free3;

    // Stage advance: a stage loads when it is empty or its content moves on.
    assign free3   = !r_v3 || i_out_ready;
    assign free2   = !r_v2 || free3;
    assign free1   = !r_v1 || free2;
    assign o_ready = free1;

    // Tap products, one per row, kernel column and channel.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    n_prod[r][k][c] = PW'($signed(i_kern[r][k*COEF_BITS +: COEF_BITS])
                                      * $signed({1'b0, i_taps[k][r][c]}));
                end
            end
        end
    end

    // Per-channel sums of the nine products.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = (SW'(r_prod[0][0][c]) + SW'(r_prod[0][1][c]) + SW'(r_prod[0][2][c]))
                     + (SW'(r_prod[1][0][c]) + SW'(r_prod[1][1][c]) + SW'(r_prod[1][2][c]))
                     + (SW'(r_prod[2][0][c]) + SW'(r_prod[2][1][c]) + SW'(r_prod[2][2][c]));
        end
    end

    // Round to nearest and clamp, or compare red against the threshold.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rnd[c] = (SW+1)'(r_sum[c]) + (SW+1)'(1 << (FRAC_W - 1));
            if (i_bin_en) begin
                n_pix[c] = (r_sum[0] > SW'(i_level)) ? '1 : '0;
            end else if (rnd[c][SW]) begin
                n_pix[c] = '0;
            end else if (|rnd[c][SW-1:FRAC_W+PIX_W]) begin
                n_pix[c] = '1;
            end else begin
                n_pix[c] = rnd[c][FRAC_W +: PIX_W];
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_load;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (free1 && i_load) begin
            r_prod <= n_prod;
            r_tag1 <= i_tag;
        end
        if (free2 && r_v1) begin
            r_sum  <= n_sum;
            r_tag2 <= r_tag1;
        end
        if (free3 && r_v2) begin
            r_pix  <= n_pix;
            r_tag3 <= r_tag2;
        end
    end

    assign o_valid = r_v3;
    assign o_pix   = r_pix;
    assign o_tag   = r_tag3;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench of the 3x3 convolution / threshold filter core.
// Drives pixel and drain transfers, predicts each filtered pixel and checks it.
// Depends on cfx_pkg and conv3x3_threshold_filter_core.
`timescale 1ns / 1ps

module testbench;
    import cfx_pkg::*;

    localparam int MAXW = 1024;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } t_expected_pixel;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    // Predictor copy of the registers and of the filter state.
    logic [10:0] cfg_width;
    logic [15:0] cfg_height;
    logic [47:0] cfg_kernel [3];
    logic [23:0] cfg_level;
    logic        cfg_binarize;
    logic [23:0] row_older [MAXW];
    logic [23:0] row_newer [MAXW];
    logic [23:0] window [9];
    int unsigned pos_col, pos_row;

    t_expected_pixel expected_pixels[$];
    int error_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    conv3x3_threshold_filter_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver side: random stall, one decision per cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Compare every output transfer with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_expected_pixel e;
        if (i_rst_n && m_tvalid && m_tready) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                e = expected_pixels.pop_front();
                if (m_tdata !== {e.blue, e.green, e.red} || m_tlast !== e.row_end
                        || m_tuser[0] !== e.frame_end)
                    report_mismatch($sformatf("got rgb %h last %b end %b, want %h %b %b",
                        m_tdata, m_tlast, m_tuser[0], {e.blue, e.green, e.red},
                        e.row_end, e.frame_end));
            end
        end
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAXW) return MAXW;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic longint coefficient(int r, int k);
        logic signed [15:0] c;
        c = cfg_kernel[r][k*16 +: 16];
        return longint'(c);
    endfunction

    // Weighted sums of the window and the resulting output pixel.
    function automatic void filter_pixel(input int s0, input int s1, input int s2,
                                         input int unsigned ox, input int unsigned oy);
        longint sums [3];
        int sel [3];
        longint t, px;
        longint level;
        t_expected_pixel e;
        logic [7:0] v [3];
        int unsigned w, h;
        w = eff_width();
        h = eff_height();
        sel[0] = s0; sel[1] = s1; sel[2] = s2;
        sums = '{0, 0, 0};
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                for (int c = 0; c < 3; c++) begin
                    px = longint'(window[r*3 + sel[k]][c*8 +: 8]);
                    sums[c] += coefficient(r, k) * px;
                end
        if (cfg_binarize) begin
            level = longint'($signed(cfg_level));
            for (int c = 0; c < 3; c++) v[c] = (sums[0] > level) ? 8'hFF : 8'h00;
        end else begin
            for (int c = 0; c < 3; c++) begin
                t = sums[c] + 2048;
                if (t <= 0) v[c] = 0;
                else if ((t >>> 12) > 255) v[c] = 8'hFF;
                else v[c] = t[19:12];
            end
        end
        e.red = v[0];
        e.green = v[1];
        e.blue = v[2];
        e.row_end = (ox == w - 1);
        e.frame_end = (ox == w - 1) && (oy == h - 1);
        expected_pixels.insert(expected_pixels.size(), e);
    endfunction

    // Advance the predicted filter state by one input transfer.
    function automatic void predict_transfer(input logic drain, input logic [23:0] p);
        int unsigned w, h, x, y;
        longint unsigned last_pos;
        logic [23:0] a, b, col [3];
        bit take, ready;
        w = eff_width();
        h = eff_height();
        last_pos = longint'(w) * h + w;
        if (pos_col >= w || longint'(pos_row) * w + pos_col > last_pos) begin
            pos_col = 0;
            pos_row = 0;
        end
        x = pos_col;
        y = pos_row;
        if (drain && y < h) return;
        take = !drain && y < h;
        ready = (y >= 2) || (y == 1 && x >= 1);
        if (x == 0 && ready) filter_pixel((w > 1) ? 1 : 2, 2, 2, w - 1, y - 2);
        a = row_older[x];
        b = row_newer[x];
        if (y == 0) begin
            col[0] = p; col[1] = p; col[2] = p;
        end else begin
            col[0] = (y == 1) ? b : a;
            col[1] = b;
            col[2] = take ? p : b;
        end
        for (int r = 0; r < 3; r++) begin
            window[r*3] = window[r*3 + 1];
            window[r*3 + 1] = window[r*3 + 2];
            window[r*3 + 2] = col[r];
        end
        if (take) begin
            row_older[x] = b;
            row_newer[x] = p;
        end
        if (x >= 1 && ready) filter_pixel((x == 1) ? 1 : 0, 1, 2, x - 1, y - 1);
        if (longint'(y) * w + x >= last_pos) begin
            pos_col = 0;
            pos_row = 0;
        end else if (x + 1 >= w) begin
            pos_col = 0;
            pos_row = y + 1;
        end else begin
            pos_col = x + 1;
        end
    endfunction

    // Send one transfer, with a random gap before it, and wait for acceptance.
    // The valid flag stays high afterwards until the next gap, register write or wait.
    task automatic send_item(input t_req kind, input logic [23:0] rgb);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= rgb;
        do @(posedge i_clk); while (!s_tready);
        predict_transfer(kind == REQ_DRAIN, rgb);
    endtask

    // Write one register through the configuration port, then leave the port idle before returning.
    task automatic write_register(input t_reg_idx idx, input logic [63:0] value);
        s_tvalid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = value[10:0];
            REG_FRAME_HEIGHT: cfg_height = value[15:0];
            REG_KERN_TOP:     cfg_kernel[0] = value[47:0];
            REG_KERN_MID:     cfg_kernel[1] = value[47:0];
            REG_KERN_BOT:     cfg_kernel[2] = value[47:0];
            REG_BIN_LEVEL:    cfg_level = value[23:0];
            REG_BIN_ENABLE:   cfg_binarize = value[0];
            default: ;
        endcase
    endtask

    // Wait until every expected pixel has come out, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [23:0] random_rgb();
        return $urandom_range(24'hFFFFFF);
    endfunction

    // Feed one whole frame of pixels, then drain it with a mix of drain and pixel transfers.
    task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(9) == 0) send_item(REQ_DRAIN, random_rgb());
            send_item(REQ_PIXEL, random_rgb());
        end
        for (int i = 0; i <= w; i++)
            send_item($urandom_range(3) == 0 ? REQ_PIXEL : REQ_DRAIN, random_rgb());
    endtask

    function automatic logic [47:0] random_kernel_row();
        logic [47:0] k;
        for (int i = 0; i < 3; i++)
            k[i*16 +: 16] = 16'($signed($urandom_range(4096)) - 2048);
        return k;
    endfunction

    // Directed: identity kernel, extreme pixels, border cases, idle drains.
    task automatic test_directed();
        set_geometry(3, 2);
        send_item(REQ_DRAIN, 24'h0);
        send_item(REQ_PIXEL, 24'h000000);
        send_item(REQ_PIXEL, 24'hFFFFFF);
        send_item(REQ_DRAIN, 24'h0);
        send_item(REQ_PIXEL, 24'hFF00FF);
        send_item(REQ_PIXEL, 24'h00FF00);
        send_item(REQ_PIXEL, 24'hAA55AA);
        send_item(REQ_PIXEL, 24'h55AA55);
        for (int i = 0; i < 5; i++) send_item(REQ_PIXEL, 24'h123456);
        send_item(REQ_DRAIN, 24'h0);
        wait_idle();
        // Extreme kernel: top and middle rows all maximum positive, bottom row all maximum negative.
        write_register(REG_KERN_TOP, 48'h7FFF_7FFF_7FFF);
        write_register(REG_KERN_MID, 48'h7FFF_7FFF_7FFF);
        write_register(REG_KERN_BOT, 48'h8000_8000_8000);
        set_geometry(1, 1);
        send_frame(1, 1, 0);
        wait_idle();
        set_geometry(0, 0);
        send_frame(1, 1, 0);
        wait_idle();
    endtask

    // Random frames in plain mode with random kernels and small geometries.
    task automatic test_plain_frames(input int frames);
        for (int f = 0; f < frames; f++) begin
            int unsigned w, h;
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            write_register(REG_KERN_TOP, random_kernel_row());
            write_register(REG_KERN_MID, random_kernel_row());
            write_register(REG_KERN_BOT, random_kernel_row());
            set_geometry(w, h);
            send_frame(w, h, 1);
            wait_idle();
        end
    endtask

    // Threshold mode with random and extreme levels.
    task automatic test_threshold_frames(input int frames);
        write_register(REG_BIN_ENABLE, 1);
        for (int f = 0; f < frames; f++) begin
            int unsigned w, h;
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            case (f % 4)
                0: write_register(REG_BIN_LEVEL, 24'h7FFFFF);
                1: write_register(REG_BIN_LEVEL, 24'h800000);
                default: write_register(REG_BIN_LEVEL, $urandom_range(24'hFFFFFF));
            endcase
            write_register(REG_KERN_MID, random_kernel_row());
            set_geometry(w, h);
            send_frame(w, h, 1);
            wait_idle();
        end
        write_register(REG_BIN_ENABLE, 0);
    endtask

    // A wide two-row frame, then a tall frame cut short.
    task automatic test_wide_frame();
        set_geometry(120, 2);
        send_frame(120, 2, 0);
        wait_idle();
        set_geometry(4, 65535);
        for (int i = 0; i < 30; i++) send_item(REQ_PIXEL, random_rgb());
        wait_idle();
        // Shrinking the geometry mid-frame restarts the frame.
        set_geometry(2, 2);
        send_frame(2, 2, 0);
        wait_idle();
    endtask

    initial begin
        cfg_width = 11'd1024;
        cfg_height = 16'd768;
        cfg_kernel[0] = '0;
        cfg_kernel[1] = 48'd268435456;
        cfg_kernel[2] = '0;
        cfg_level = '0;
        cfg_binarize = 1'b0;
        for (int i = 0; i < 9; i++) window[i] = '0;
        pos_col = 0;
        pos_row = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 30;
        receiver_idle_pct = 70;
        test_directed();
        test_plain_frames(10);
        sender_idle_pct = 70;
        receiver_idle_pct = 30;
        test_threshold_frames(10);
        test_plain_frames(5);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_wide_frame();
        test_threshold_frames(4);
        test_plain_frames(4);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d filtered pixels over plain and threshold frames,", result_count);
        $display("border widths, extreme kernels and geometry changes.");
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d pixels missing", error_count,
                     expected_pixels.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
